FILE: src/sarf_pkg.sv
// ----------------------------------------------------------------------------
// sarf_pkg: shared types and constants for the anti-replay filter
// verdict codes and the per-slot record carried along the cell chain
// ----------------------------------------------------------------------------
package sarf_pkg;

	localparam int ID_W   = 8;
	localparam int SES_W  = 16;
	localparam int SEQ_W  = 32;
	localparam int TIME_W = 32;
	localparam int VERD_W = 3;
	localparam int SLOT_W = 3;
	localparam int WBITS_W = 8;

	localparam logic [VERD_W-1:0] VERD_ACCEPT   = 3'd0;
	localparam logic [VERD_W-1:0] VERD_ZERO_SES = 3'd1;
	localparam logic [VERD_W-1:0] VERD_STALE    = 3'd2;
	localparam logic [VERD_W-1:0] VERD_OUTSIDE  = 3'd3;
	localparam logic [VERD_W-1:0] VERD_DUP      = 3'd4;

	localparam logic [SEQ_W-1:0] SEQ_HALF     = 32'h8000_0000;
	localparam logic [SES_W-1:0] SESSION_HALF = 16'h8000;

	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   id;
		logic [SES_W-1:0]  session;
		logic [SEQ_W-1:0]  highest;
		logic [WBITS_W-1:0] wbits;
		logic [TIME_W-1:0] last_seen;
	} slot_rec_t;

endpackage

FILE: src/sarf_cell.sv
// ----------------------------------------------------------------------------
// sarf_cell: one table slot of the rotating chain
// holds a record, loads from its neighbor on shift, or from the write port
// ----------------------------------------------------------------------------
module sarf_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  logic                wr_en,
	input  sarf_pkg::slot_rec_t wr_rec,
	input  sarf_pkg::slot_rec_t prev_rec,
	output sarf_pkg::slot_rec_t rec
);
	import sarf_pkg::*;

	logic      valid_q;
	slot_rec_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= wr_rec.valid;
		end else if (shift) begin
			valid_q <= prev_rec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			data_q <= wr_rec;
		end else if (shift) begin
			data_q <= prev_rec;
		end
	end

	always_comb begin
		rec = data_q;
		rec.valid = valid_q;
	end

endmodule

FILE: src/session_anti_replay_filter_core.sv
// ----------------------------------------------------------------------------
// session_anti_replay_filter_core: per-source replay filter with sessions
// ----------------------------------------------------------------------------
// from start, a request passes through ST_SCAN, ST_PICK, ST_WIN and ST_OUT to the
// result strobe (zero session: from ST_IDLE straight to ST_OUT); one request at a
// time, busy stays high until the result
// the slot records rotate once around a ring of cells for the scan
// reset clears all slot valid bits and the control state; results cannot stall
// ----------------------------------------------------------------------------
module session_anti_replay_filter_core #(
	parameter int NUM_SOURCES = 8,
	parameter int WINDOW_SIZE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  src_id,
	input  logic [15:0] boot_id,
	input  logic [31:0] seq_num,
	input  logic        is_reliable,
	input  logic [31:0] now_ms,
	output logic        done,
	output logic [2:0]  verdict,
	output logic        session_changed,
	output logic [2:0]  slot_index
);
	import sarf_pkg::*;

	localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int CNT_W = $clog2(NUM_SOURCES + 1);
	localparam logic [WBITS_W-1:0] WIN_MASK = WBITS_W'((9'd1 << WINDOW_SIZE) - 9'd1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_PICK  = 5'b00100,
		ST_WIN   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;

	logic [ID_W-1:0]   src_q;
	logic [SES_W-1:0]  boot_q;
	logic [SEQ_W-1:0]  seq_q;
	logic              rel_q;
	logic [TIME_W-1:0] now_q;

	logic [CNT_W-1:0]  cnt_q;
	logic              found_q, free_q;
	logic [IDX_W-1:0]  match_q, free_idx_q, lru_idx_q;
	logic [TIME_W-1:0] lru_time_q;
	logic [IDX_W-1:0]  slot_q;
	slot_rec_t         work_q;
	logic              changed_q;
	logic [VERD_W-1:0] verd_q;

	slot_rec_t cell_rec [NUM_SOURCES];
	logic      shift;
	logic [NUM_SOURCES-1:0] wr_sel;
	slot_rec_t wr_rec;

	// ring: cell i takes from cell i+1, so cell 0 sees slot cnt_q during scan
	genvar g;
	generate
		for (g = 0; g < NUM_SOURCES; g++) begin : g_cell
			sarf_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (shift),
				.wr_en    (wr_sel[g]),
				.wr_rec   (wr_rec),
				.prev_rec (cell_rec[(g + 1) % NUM_SOURCES]),
				.rec      (cell_rec[g])
			);
		end
	endgenerate

	assign shift = (state_q == ST_SCAN);
	wire [IDX_W-1:0] scan_idx = cnt_q[IDX_W-1:0];
	slot_rec_t head;
	assign head = cell_rec[0];

	// window check on the chosen record
	slot_rec_t win_rec;
	logic [VERD_W-1:0] win_verd;
	always_comb begin
		logic [SEQ_W-1:0]  d;
		logic [WBITS_W-1:0] bits;
		logic [WBITS_W-1:0] m;
		win_rec  = work_q;
		win_verd = VERD_ACCEPT;
		bits = work_q.wbits & WIN_MASK;
		d = seq_q - work_q.highest;
		m = '0;
		if (rel_q) begin
			if (bits == '0) begin
				win_rec.highest = seq_q;
				win_rec.wbits   = WBITS_W'(1);
			end else if (d != '0 && d < SEQ_HALF) begin
				if (d >= SEQ_W'(WINDOW_SIZE)) bits = '0;
				else bits = (bits << d[2:0]) & WIN_MASK;
				win_rec.highest = seq_q;
				win_rec.wbits   = bits | WBITS_W'(1);
			end else begin
				d = work_q.highest - seq_q;
				if (d >= SEQ_W'(WINDOW_SIZE)) begin
					win_verd = VERD_OUTSIDE;
				end else begin
					m = WBITS_W'(1) << d[2:0];
					if ((bits & m) != '0) win_verd = VERD_DUP;
					else win_rec.wbits = bits | m;
				end
			end
		end
		if (win_verd == VERD_ACCEPT) win_rec.last_seen = now_q;
	end

	always_comb begin
		wr_sel = '0;
		wr_rec = win_rec;
		if (state_q == ST_WIN && verd_q == VERD_ACCEPT && win_verd == VERD_ACCEPT)
			wr_sel[slot_q] = 1'b1;
	end

	// the record read for the picked slot, after a full rotation
	slot_rec_t pick_rec;
	logic [IDX_W-1:0] pick_idx;
	logic [SES_W-1:0] sd;
	always_comb begin
		pick_idx = found_q ? match_q : (free_q ? free_idx_q : lru_idx_q);
		pick_rec = cell_rec[pick_idx];
		sd = boot_q - pick_rec.session;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (boot_id == '0) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_SCAN;
						end
						cnt_q <= '0;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(NUM_SOURCES - 1)) state_q <= ST_PICK;
				end
				ST_PICK: state_q <= ST_WIN;
				ST_WIN:  state_q <= ST_OUT;
				ST_OUT: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				src_q <= src_id;
				boot_q <= boot_id;
				seq_q <= seq_num;
				rel_q <= is_reliable;
				now_q <= now_ms;
				found_q <= 1'b0;
				free_q <= 1'b0;
				match_q <= '0;
				free_idx_q <= '0;
				lru_idx_q <= '0;
				changed_q <= 1'b0;
				slot_q <= '0;
				verd_q <= start && boot_id == '0 ? VERD_ZERO_SES : VERD_ACCEPT;
			end
			ST_SCAN: begin
				if (!found_q && head.valid && head.id == src_q) begin
					found_q <= 1'b1;
					match_q <= scan_idx;
				end
				if (!free_q && !head.valid) begin
					free_q <= 1'b1;
					free_idx_q <= scan_idx;
				end
				if (cnt_q == '0 || head.last_seen < lru_time_q) begin
					lru_time_q <= head.last_seen;
					lru_idx_q <= scan_idx;
				end
			end
			ST_PICK: begin
				slot_q <= pick_idx;
				work_q <= pick_rec;
				if (found_q) begin
					if (pick_rec.session != boot_q) begin
						if (!(sd != '0 && sd < SESSION_HALF)) begin
							verd_q <= VERD_STALE;
						end else begin
							work_q.session <= boot_q;
							work_q.highest <= '0;
							work_q.wbits <= '0;
							changed_q <= 1'b1;
						end
					end
				end else begin
					work_q.valid <= 1'b1;
					work_q.id <= src_q;
					work_q.session <= boot_q;
					work_q.highest <= '0;
					work_q.wbits <= '0;
					work_q.last_seen <= '0;
					changed_q <= 1'b1;
				end
			end
			ST_WIN: begin
				if (verd_q == VERD_ACCEPT) verd_q <= win_verd;
			end
			default: ;
		endcase
	end

	// an adopted session always passes the window, so one write in ST_WIN covers it
	assign busy = (state_q != ST_IDLE);
	assign verdict = verd_q;
	assign session_changed = (verd_q == VERD_STALE || verd_q == VERD_ZERO_SES)
		? 1'b0 : changed_q;
	assign slot_index = (verd_q == VERD_ZERO_SES) ? 3'd0 : 3'(slot_q);

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for session_anti_replay_filter_core
// random packet headers drive the filter; a model of the source table and
// sliding window predicts each verdict, checked against the result strobe
// ----------------------------------------------------------------------------
module tb;
	import sarf_pkg::*;

	localparam int NSRC = 8;
	localparam int WIN  = 8;

	typedef struct packed {
		logic [VERD_W-1:0] verd;
		logic              changed;
		logic [SLOT_W-1:0] slot;
	} verdict_t;

	class replay_scoreboard;
		bit          valid_q[NSRC];
		logic [7:0]  id_q[NSRC];
		logic [15:0] ses_q[NSRC];
		logic [31:0] top_q[NSRC];
		logic [7:0]  bits_q[NSRC];
		logic [31:0] seen_q[NSRC];
		verdict_t    pending[$];
		int          errors;

		function void clear();
			for (int i = 0; i < NSRC; i++) valid_q[i] = 0;
			pending.delete();
			errors = 0;
		endfunction

		function logic [VERD_W-1:0] window_check(int s, logic [31:0] seq);
			logic [31:0] d;
			logic [7:0]  b;
			logic [7:0]  m;
			b = bits_q[s];
			d = seq - top_q[s];
			if (b == 0) begin
				top_q[s] = seq;
				bits_q[s] = 8'h01;
				return VERD_ACCEPT;
			end
			if (d != 0 && d < SEQ_HALF) begin
				b = (d >= WIN) ? 8'h00 : 8'(b << d);
				top_q[s] = seq;
				bits_q[s] = b | 8'h01;
				return VERD_ACCEPT;
			end
			d = top_q[s] - seq;
			if (d >= WIN) return VERD_OUTSIDE;
			m = 8'h01 << d;
			if ((b & m) != 0) return VERD_DUP;
			bits_q[s] = b | m;
			return VERD_ACCEPT;
		endfunction

		function void note_request(logic [7:0] src, logic [15:0] boot, logic [31:0] seq,
				logic rel, logic [31:0] now);
			verdict_t r;
			int slot;
			bit found;
			logic [15:0] sd;
			r = '0;
			slot = 0;
			found = 0;
			if (boot == 0) begin
				r.verd = VERD_ZERO_SES;
				pending.push_back(r);
				return;
			end
			for (int i = 0; i < NSRC; i++)
				if (!found && valid_q[i] && id_q[i] == src) begin
					slot = i;
					found = 1;
				end
			if (found) begin
				if (ses_q[slot] != boot) begin
					sd = boot - ses_q[slot];
					if (!(sd != 0 && sd < SESSION_HALF)) begin
						r.verd = VERD_STALE;
						r.slot = SLOT_W'(slot);
						pending.push_back(r);
						return;
					end
					ses_q[slot] = boot;
					top_q[slot] = 0;
					bits_q[slot] = 0;
					r.changed = 1;
				end
			end else begin
				found = 0;
				for (int i = 0; i < NSRC; i++)
					if (!found && !valid_q[i]) begin
						slot = i;
						found = 1;
					end
				if (!found) begin
					slot = 0;
					for (int i = 1; i < NSRC; i++)
						if (seen_q[i] < seen_q[slot]) slot = i;
				end
				valid_q[slot] = 1;
				id_q[slot] = src;
				seen_q[slot] = 0;
				ses_q[slot] = boot;
				top_q[slot] = 0;
				bits_q[slot] = 0;
				r.changed = 1;
			end
			r.verd = rel ? window_check(slot, seq) : VERD_ACCEPT;
			if (r.verd == VERD_ACCEPT) seen_q[slot] = now;
			r.slot = SLOT_W'(slot);
			pending.push_back(r);
		endfunction

		function void check_result(verdict_t got);
			verdict_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.verd !== want.verd) begin
				$display("%0t: verdict expected %0d actual %0d", $time, want.verd, got.verd);
				errors++;
			end
			if (got.changed !== want.changed) begin
				$display("%0t: session_changed expected %0d actual %0d", $time,
					want.changed, got.changed);
				errors++;
			end
			if (got.slot !== want.slot) begin
				$display("%0t: slot_index expected %0d actual %0d", $time, want.slot, got.slot);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  src_id;
	logic [15:0] boot_id;
	logic [31:0] seq_num;
	logic        is_reliable;
	logic [31:0] now_ms;
	logic        done;
	logic [2:0]  verdict;
	logic        session_changed;
	logic [2:0]  slot_index;

	replay_scoreboard sb;
	logic [15:0] src_session[4];
	logic [31:0] src_seq[4];
	logic [31:0] clock_ms;
	int burst_left;

	session_anti_replay_filter_core #(.NUM_SOURCES(NSRC), .WINDOW_SIZE(WIN)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.src_id(src_id), .boot_id(boot_id), .seq_num(seq_num),
		.is_reliable(is_reliable), .now_ms(now_ms), .done(done),
		.verdict(verdict), .session_changed(session_changed), .slot_index(slot_index)
	);

	always #6 clk = ~clk;

	always @(posedge clk)
		if (arst_n && done)
			sb.check_result(verdict_t'({verdict, session_changed, slot_index}));

	// one request; requests come in bursts with random idle gaps between bursts
	task automatic send_request(logic [7:0] src, logic [15:0] boot, logic [31:0] seq,
			logic rel, logic [31:0] now);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 20)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		src_id = src;
		boot_id = boot;
		seq_num = seq;
		is_reliable = rel;
		now_ms = now;
		start = 1;
		do @(posedge clk); while (busy);
		sb.note_request(src, boot, seq, rel, now);
		@(negedge clk);
		start = 0;
	endtask

	task automatic wait_drained();
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	// well-formed traffic from a small group of sources with random content
	task automatic send_flow();
		int k;
		logic [31:0] seq;
		logic [15:0] boot;
		k = $urandom_range(0, 3);
		clock_ms += $urandom_range(0, 50);
		case ($urandom_range(0, 19))
			0: src_session[k] += 16'($urandom_range(1, 3));
			1: src_session[k] -= 16'd1;
			default: ;
		endcase
		if (src_session[k] == 0) src_session[k] = 16'd1;
		boot = src_session[k];
		case ($urandom_range(0, 9))
			0, 1, 2, 3: seq = src_seq[k] + 1;
			4, 5: seq = src_seq[k] - $urandom_range(0, 9);
			6: seq = src_seq[k] + $urandom_range(2, 12);
			7: seq = src_seq[k] + $urandom;
			default: seq = src_seq[k];
		endcase
		if (seq - src_seq[k] < 32'h8000_0000) src_seq[k] = seq;
		send_request(8'(8 * k + 3), boot, seq, $urandom_range(0, 7) != 0, clock_ms);
	endtask

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		sb = new();
		sb.clear();
		clk = 0;
		arst_n = 0;
		start = 0;
		src_id = 0;
		boot_id = 0;
		seq_num = 0;
		is_reliable = 0;
		now_ms = 0;
		burst_left = 0;
		clock_ms = 0;
		for (int i = 0; i < 4; i++) begin
			src_session[i] = 16'($urandom_range(1, 65535));
			src_seq[i] = $urandom;
		end
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// zero session, first packet, duplicate, window edges, session changes
		send_request(8'hFF, 16'h0000, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
		send_request(8'h00, 16'hFFFF, 32'hFFFF_FFFF, 1, 32'h0000_0010);
		send_request(8'h00, 16'hFFFF, 32'hFFFF_FFFF, 1, 32'h0000_0011);
		send_request(8'h00, 16'hFFFF, 32'h0000_0001, 1, 32'h0000_0012);
		send_request(8'h00, 16'hFFFF, 32'hFFFF_FFFA, 1, 32'h0000_0013);
		send_request(8'h00, 16'hFFFF, 32'hFFFF_FFF9, 1, 32'h0000_0014);
		send_request(8'h00, 16'hFFFF, 32'h0000_0001, 1, 32'h0000_0015);
		send_request(8'h00, 16'hFFFF, 32'h0000_0010, 1, 32'h0000_0016);
		send_request(8'h00, 16'hFFFF, 32'h8000_0010, 1, 32'h0000_0017);
		send_request(8'h00, 16'hFFFF, 32'h8000_0011, 0, 32'h0000_0018);
		send_request(8'h00, 16'h7FFF, 32'h0000_0000, 1, 32'h0000_0019);
		send_request(8'h00, 16'h7FFE, 32'h0000_0000, 1, 32'h0000_001A);
		send_request(8'h00, 16'h0001, 32'h0000_0005, 1, 32'h0000_001B);
		// fill every slot, then force evictions
		for (int i = 1; i < 10; i++)
			send_request(8'(i * 17), 16'h5555, 32'(i), 1'(i % 2), 32'(i == 4 ? 0 : 100 + i));
		send_request(8'hAA, 16'hAAAA, 32'h5555_5555, 1, 32'h8000_0000);
		wait_drained();

		for (int n = 0; n < 1180; n++) begin
			if (n == 600) wait_drained();
			if ($urandom_range(0, 9) < 7) send_flow();
			else send_request(8'($urandom), 16'($urandom_range(0, 12) == 0 ? 0 : $urandom),
				$urandom, 1'($urandom), $urandom);
		end

		wait_drained();
		repeat (30) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
